// ===== hdl/modexp_pkg.sv =====
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared widths and register map for the modular exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

  // default operand width (message, exponent, modulus, result)
  localparam int unsigned MODEXP_WIDTH = 32;

  // configuration port: one register, byte address 0
  localparam int unsigned CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_MODULUS = 1'b0;

  // data bus width that holds a register of the given width
  function automatic int unsigned cfg_data_width(input int unsigned w);
    return (w > 32) ? 64 : 32;
  endfunction

endpackage

// ===== hdl/modexp_if.sv =====
// ----------------------------------------------------------------------------
// modexp channel interfaces
// Valid/ready channels for operand items and result items.
// ----------------------------------------------------------------------------
interface modexp_in_if
  import modexp_pkg::*;
#(
  parameter int unsigned WIDTH = MODEXP_WIDTH
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] message;
  logic [WIDTH-1:0] exponent;

  modport source (output valid, output message, output exponent, input ready);
  modport sink   (input valid, input message, input exponent, output ready);
endinterface

interface modexp_out_if
  import modexp_pkg::*;
#(
  parameter int unsigned WIDTH = MODEXP_WIDTH
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] power_residue;

  modport source (output valid, output power_residue, input ready);
  modport sink   (input valid, input power_residue, output ready);
endinterface

// ===== hdl/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes message^exponent mod modulus by square and multiply.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   operand item (message, exponent), valid/ready. Ready is high only
//           while the sequencer is idle; one item is worked at a time.
//   out_ch  result item (power_residue), valid/ready, from an output register.
//           A result waiting there does not block the next operand item.
//   APB     register 0 (byte address 0) is the modulus; reset value 1.
//           Write it only while no item is in flight.
// Operation:
//   One shared add/compare unit does a doubling and an optional add modulo
//   the modulus per cycle. The message is first reduced bit-serially.
//   Then for each of the WIDTH exponent bits, MSB first, the running value
//   is squared and, for a one bit, multiplied by the reduced message.
//   A zero modulus skips the computation and answers 0.
// Reset: rst_n (synchronous, active low) idles the sequencer, drops any
//   pending result and sets the modulus to 1.
// Stall: a result held in the output register keeps a finished item waiting
//   in the final state until the receiver takes the older one.
// ----------------------------------------------------------------------------
module modular_exponentiation
  import modexp_pkg::*;
#(
  parameter int unsigned WIDTH = MODEXP_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  modexp_in_if.sink                         in_ch,
  modexp_out_if.source                      out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [CFG_ADDR_W-1:0]             paddr,
  input  logic [cfg_data_width(WIDTH)-1:0]  pwdata,
  output logic [cfg_data_width(WIDTH)-1:0]  prdata,
  output logic                              pready
);

  localparam int unsigned DW    = cfg_data_width(WIDTH);
  localparam int unsigned CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RED  = 3'd1;  // reduce message mod modulus
  localparam logic [2:0] ST_SQR  = 3'd2;  // square running value
  localparam logic [2:0] ST_MUL  = 3'd3;  // multiply by reduced message
  localparam logic [2:0] ST_FIN  = 3'd4;  // hand result to output register

  logic [2:0]       state_r, state_nxt;
  logic [WIDTH-1:0] mod_r, mod_nxt;
  logic [WIDTH-1:0] base_r, base_nxt;     // reduced message
  logic [WIDTH-1:0] exp_r, exp_nxt;       // exponent, shifted left per bit
  logic [WIDTH-1:0] acc_r, acc_nxt;       // running power
  logic [WIDTH-1:0] part_r, part_nxt;     // partial product of the multiply
  logic [WIDTH-1:0] mb_r, mb_nxt;         // multiplier bits, MSB first
  logic [CNT_W-1:0] cnt_r, cnt_nxt;       // inner bit count
  logic [CNT_W-1:0] ecnt_r, ecnt_nxt;     // exponent bit count
  logic             out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0] out_data_r, out_data_nxt;

  // shared unit: r = ((2*part + bit_in) mod m + (add_en ? addend : 0)) mod m
  logic             bit_in;
  logic             add_en;
  logic [WIDTH-1:0] addend;
  logic [WIDTH:0]   dbl;
  logic [WIDTH-1:0] dbl_red;
  logic [WIDTH:0]   sum;
  logic [WIDTH-1:0] unit_res;

  logic             cfg_wr;
  logic             in_fire;
  logic [WIDTH-1:0] one_mod;   // 1 mod m

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && (paddr == REG_MODULUS);
  assign prdata  = (paddr == REG_MODULUS) ? DW'(mod_r) : '0;
  assign in_ch.ready          = (state_r == ST_IDLE);
  assign in_fire              = in_ch.valid && (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.power_residue = out_data_r;
  assign one_mod = (mod_r == WIDTH'(1)) ? '0 : WIDTH'(1);

  // select unit operands by phase
  always_comb begin
    bit_in = 1'b0;
    add_en = 1'b0;
    addend = base_r;
    case (state_r)
      ST_RED: begin
        bit_in = mb_r[WIDTH-1];
      end
      ST_SQR: begin
        add_en = mb_r[WIDTH-1];
        addend = acc_r;
      end
      ST_MUL: begin
        add_en = mb_r[WIDTH-1];
        addend = base_r;
      end
      default: begin
        add_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    dbl      = {part_r, bit_in};
    dbl_red  = (dbl >= {1'b0, mod_r}) ? WIDTH'(dbl - {1'b0, mod_r}) : dbl[WIDTH-1:0];
    sum      = {1'b0, dbl_red} + {1'b0, addend};
    if (!add_en) begin
      unit_res = dbl_red;
    end else if (sum >= {1'b0, mod_r}) begin
      unit_res = WIDTH'(sum - {1'b0, mod_r});
    end else begin
      unit_res = sum[WIDTH-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    mod_nxt       = mod_r;
    base_nxt      = base_r;
    exp_nxt       = exp_r;
    acc_nxt       = acc_r;
    part_nxt      = part_r;
    mb_nxt        = mb_r;
    cnt_nxt       = cnt_r;
    ecnt_nxt      = ecnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;

    if (cfg_wr) begin
      mod_nxt = pwdata[WIDTH-1:0];
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          mb_nxt   = in_ch.message;
          exp_nxt  = in_ch.exponent;
          part_nxt = '0;
          cnt_nxt  = CNT_LAST;
          if (mod_r == '0) begin
            // zero modulus: no computation, result is zero
            acc_nxt   = '0;
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_RED;
          end
        end
      end
      ST_RED: begin
        part_nxt = unit_res;
        mb_nxt   = mb_r << 1;
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          base_nxt  = unit_res;
          acc_nxt   = one_mod;
          mb_nxt    = one_mod;
          part_nxt  = '0;
          cnt_nxt   = CNT_LAST;
          ecnt_nxt  = CNT_LAST;
          state_nxt = ST_SQR;
        end
      end
      ST_SQR, ST_MUL: begin
        part_nxt = unit_res;
        mb_nxt   = mb_r << 1;
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          acc_nxt  = unit_res;
          mb_nxt   = unit_res;
          part_nxt = '0;
          cnt_nxt  = CNT_LAST;
          if ((state_r == ST_SQR) && exp_r[WIDTH-1]) begin
            state_nxt = ST_MUL;
          end else begin
            // advance to next exponent bit
            exp_nxt  = exp_r << 1;
            ecnt_nxt = ecnt_r - CNT_W'(1);
            state_nxt = (ecnt_r == '0) ? ST_FIN : ST_SQR;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = acc_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mod_r       <= WIDTH'(1);
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      ecnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      mod_r       <= mod_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      ecnt_r      <= ecnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r     <= base_nxt;
    exp_r      <= exp_nxt;
    acc_r      <= acc_nxt;
    part_r     <= part_nxt;
    mb_r       <= mb_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
